/* rtl/dcd_pkg.sv */
package dcd_pkg;

    localparam int unsigned OmegaMax   = 99;
    localparam int unsigned Scale      = 25500;
    localparam int unsigned OmegaReset = 95;
    localparam int unsigned AirReset   = 240;
    localparam int unsigned QuotBits   = 9;

    // register indexes
    localparam logic CFG_OMEGA   = 1'b0;
    localparam logic CFG_AIRLIMIT = 1'b1;

    // pass codes
    localparam logic KIND_ANALYZE = 1'b0;
    localparam logic KIND_RECOVER = 1'b1;

    // one queued recover word
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] dark;
        logic [7:0] air;
        logic [6:0] omega;
    } dcd_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } dcd_state_t;

endpackage

/* rtl/dark_channel_defog_pixel.sv */
// channel | signals                                   | direction
// cfg     | cfg_we, cfg_index, cfg_data               | in
// input   | in_valid/in_stall, kind, first_of_frame,  | in
//         | blue_in, green_in, red_in                 |
// output  | out_valid/out_stall, blue_out, green_out, | out
//         | red_out, dark_out                         |
// analyze words update the frame maximum and produce nothing
// a recover word passes through these back-end steps: denominator, numerator,
// 9 restoring divide steps (one quotient bit each) and result load
// a two-word queue lets the front keep accepting while the back divides
// in_stall is high only while the queue is full; reset clears the queue, sequencer, frame maximum and out_valid
module dark_channel_defog_pixel (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic       first_of_frame,
    input  logic [7:0] blue_in,
    input  logic [7:0] green_in,
    input  logic [7:0] red_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] blue_out,
    output logic [7:0] green_out,
    output logic [7:0] red_out,
    output logic [7:0] dark_out
);
    import dcd_pkg::*;

    logic     push;
    logic     pop;
    logic     full;
    logic     not_empty;
    dcd_job_t push_job;
    dcd_job_t pop_job;

    assign in_stall = full;

    // front end
    dcd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (!full),
        .kind           (kind),
        .first_of_frame (first_of_frame),
        .blue_in        (blue_in),
        .green_in       (green_in),
        .red_in         (red_in),
        .push           (push),
        .job            (push_job)
    );

    // job queue
    dcd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .pop_job   (pop_job)
    );

    // back end
    dcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out),
        .dark_out  (dark_out)
    );

endmodule

/* rtl/dcd_front.sv */
module dcd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              kind,
    input  logic              first_of_frame,
    input  logic [7:0]        blue_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        red_in,
    output logic              push,
    output dcd_pkg::dcd_job_t job
);
    import dcd_pkg::*;

    logic [6:0] omega_reg;
    logic [7:0] airlimit_reg;
    logic [7:0] max_reg;
    logic [7:0] max_next;
    logic [7:0] dark;
    logic [7:0] min_bg;
    logic [7:0] base;
    logic       accept;

    assign accept = in_valid && in_ready;

    // dark value of the pixel
    assign min_bg = (blue_in < green_in) ? blue_in : green_in;
    assign dark   = (min_bg < red_in) ? min_bg : red_in;

    // running frame maximum
    always_comb
    begin
        base     = first_of_frame ? 8'd0 : max_reg;
        max_next = (dark > base) ? dark : base;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg    <= 7'(OmegaReset);
            airlimit_reg <= 8'(AirReset);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OMEGA:    omega_reg    <= cfg_data[6:0];
                CFG_AIRLIMIT: airlimit_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= 8'd0;
        else if (accept && kind == KIND_ANALYZE)
            max_reg <= max_next;
    end

    // recover words go to the queue
    assign push       = accept && kind == KIND_RECOVER;
    assign job.blue   = blue_in;
    assign job.green  = green_in;
    assign job.red    = red_in;
    assign job.dark   = dark;
    assign job.air    = (max_reg < airlimit_reg) ? max_reg : airlimit_reg;
    assign job.omega  = (omega_reg > 7'(OmegaMax)) ? 7'(OmegaMax) : omega_reg;

endmodule

/* rtl/dcd_fifo.sv */
module dcd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dcd_pkg::dcd_job_t push_job,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output dcd_pkg::dcd_job_t pop_job
);
    import dcd_pkg::*;

    dcd_job_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_job   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && push))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == 2'd0))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

/* rtl/dcd_back.sv */
module dcd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  dcd_pkg::dcd_job_t job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        blue_out,
    output logic [7:0]        green_out,
    output logic [7:0]        red_out,
    output logic [7:0]        dark_out
);
    import dcd_pkg::*;

    dcd_state_t  state_reg;
    dcd_state_t  state_next;
    dcd_job_t    job_reg;
    logic [14:0] den_reg;
    logic [3:0]  step_reg;
    logic [24:0] rem_reg [3];
    logic [24:0] rem_next [3];
    logic [8:0]  quot_reg [3];
    logic        neg_reg [3];
    logic        sat_reg [3];
    logic [7:0]  chan [3];
    logic [7:0]  res [3];
    logic [15:0] den2;
    logic [24:0] dshift;
    logic        out_valid_reg;
    logic        load_out;

    assign chan[0] = job_reg.blue;
    assign chan[1] = job_reg.green;
    assign chan[2] = job_reg.red;
    assign den2    = {den_reg, 1'b0};
    assign dshift  = 25'(den2) << step_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    state_next = ST_DEN;
                end
            end
            ST_DEN: state_next = ST_NUM;
            ST_NUM: state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == 4'd0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // one restoring step for each channel
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            rem_next[c] = (rem_reg[c] >= dshift) ? rem_reg[c] - dshift : rem_reg[c];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        logic signed [26:0] diff;
        logic signed [26:0] num;
        logic        [27:0] twice;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                    job_reg <= job;
            end
            ST_DEN:
            begin
                den_reg <= 15'(Scale) - 15'(job_reg.omega * job_reg.dark);
            end
            ST_NUM:
            begin
                step_reg <= 4'(QuotBits - 1);
                for (int c = 0; c < 3; c++)
                begin
                    diff  = 27'(signed'({1'b0, chan[c]}) - signed'({1'b0, job_reg.air}));
                    num   = diff * 27'sd25500 + signed'(27'(job_reg.air * den_reg));
                    twice = 28'({num, 1'b0}) + 28'(den_reg);
                    neg_reg[c]  <= num[26];
                    rem_reg[c]  <= twice[24:0];
                    sat_reg[c]  <= twice[24:0] >= (25'(den2) << QuotBits);
                    quot_reg[c] <= 9'd0;
                end
            end
            ST_DIV:
            begin
                step_reg <= step_reg - 4'd1;
                for (int c = 0; c < 3; c++)
                begin
                    rem_reg[c]                <= rem_next[c];
                    quot_reg[c][step_reg[3:0]] <= rem_reg[c] >= dshift;
                end
            end
            default: ;
        endcase
    end

    // rounding already folded in; clamp here
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (neg_reg[c])
                res[c] = 8'd0;
            else if (sat_reg[c] || quot_reg[c][8])
                res[c] = 8'd255;
            else
                res[c] = quot_reg[c][7:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            blue_out  <= res[0];
            green_out <= res[1];
            red_out   <= res[2];
            dark_out  <= job_reg.dark;
        end
    end

    assign out_valid = out_valid_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("job taken while busy");
    a_pop_den: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_DEN)
        else $error("job taken without starting");
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result lost on load");

endmodule
